>>> hdl/qcrim_pkg.sv
// Shared types and constants for the quad-channel rolling IQ mean unit.
package qcrim_pkg;

	localparam int CHANNELS = 4;
	localparam int WINDOW   = 8;
	localparam int MAX_CH   = 4;

	localparam int CH_W     = 2;
	localparam int SLOT_W   = $clog2(WINDOW);
	localparam int PHASE_W  = 3;
	localparam int ECNT_W   = SLOT_W + 1;
	localparam int SEQ_W    = 32;
	localparam int MASK_W   = 8;

	localparam int SAMPLE_W = 24;
	localparam int DEMOD_W  = SAMPLE_W + 1;
	localparam int RSUM_W   = SAMPLE_W + SLOT_W;
	localparam int DSUM_W   = DEMOD_W + SLOT_W;

	localparam int HIST_AW    = CH_W + SLOT_W;
	localparam int HIST_DEPTH = MAX_CH * WINDOW;
	localparam int SUM_DEPTH  = MAX_CH;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = MASK_W;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_I_MASK     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_Q_MASK     = 2'd2;

	localparam int S_TDATA_W = MAX_CH * SAMPLE_W;
	localparam int RES_BITS  = CH_W + SAMPLE_W + 2 * DEMOD_W + PHASE_W + SLOT_W + 1 + SEQ_W;
	localparam int M_TDATA_W = ((RES_BITS + 7) / 8) * 8;

	typedef enum logic {
		OP_EPOCH  = 1'b0,
		OP_REPORT = 1'b1
	} op_t;

	// one word of the delay-line memory
	typedef struct packed {
		logic signed [DEMOD_W-1:0]  q;
		logic signed [DEMOD_W-1:0]  i;
		logic signed [SAMPLE_W-1:0] raw;
	} hist_word_t;

	// one word of the running-sum memory
	typedef struct packed {
		logic signed [DSUM_W-1:0] q;
		logic signed [DSUM_W-1:0] i;
		logic signed [RSUM_W-1:0] raw;
	} sum_word_t;

	// per-channel work issued from the sequencer to the update stage
	typedef struct packed {
		op_t                        op;
		logic [CH_W-1:0]            ch;
		logic [SLOT_W-1:0]          slot;
		logic [PHASE_W-1:0]         phase;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       neg_i;
		logic                       neg_q;
		logic                       hist_fill;
		logic                       sum_fill;
		logic                       mean_valid;
		logic [SEQ_W-1:0]           seq;
		logic                       last;
	} issue_t;

	// one channel result of a report
	typedef struct packed {
		logic                       last;
		logic [SEQ_W-1:0]           seq;
		logic                       mean_valid;
		logic [SLOT_W-1:0]          write_pos;
		logic [PHASE_W-1:0]         phase;
		logic signed [DEMOD_W-1:0]  mean_q;
		logic signed [DEMOD_W-1:0]  mean_i;
		logic signed [SAMPLE_W-1:0] mean_raw;
		logic [CH_W-1:0]            ch;
	} res_t;

endpackage

>>> hdl/qcrim_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module qcrim_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/qcrim_seq.sv
// Input acceptance, scalar state, config registers and per-channel issue sequencer.
module qcrim_seq (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [qcrim_pkg::S_TDATA_W-1:0]         s_tdata,
	input  logic                                    s_tuser,
	input  logic                                    cfg_we,
	input  logic [qcrim_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [qcrim_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                    s2_ready,
	output logic                                    iss_valid,
	output qcrim_pkg::issue_t                       iss
);
	import qcrim_pkg::*;

	localparam logic [CH_W-1:0]   LAST_CH = CH_W'(CHANNELS - 1);
	localparam logic [ECNT_W-1:0] ECNT_FULL = ECNT_W'(WINDOW);

	typedef struct packed {
		op_t                                 op;
		logic [MAX_CH-1:0][SAMPLE_W-1:0]     samples;
		logic [SLOT_W-1:0]                   slot;
		logic [PHASE_W-1:0]                  phase;
		logic                                neg_i;
		logic                                neg_q;
		logic                                hist_fill;
		logic                                sum_fill;
		logic                                mean_valid;
		logic [SEQ_W-1:0]                    seq;
	} item_t;

	logic [PHASE_W-1:0] phase_step_q;
	logic [MASK_W-1:0]  i_mask_q;
	logic [MASK_W-1:0]  q_mask_q;

	logic [SLOT_W-1:0]  slot_q;
	logic [PHASE_W-1:0] phase_q;
	logic [ECNT_W-1:0]  ecnt_q;
	logic [SEQ_W-1:0]   seq_q;

	logic               busy_q;
	logic [CH_W-1:0]    cnt_q;
	item_t              item_q;

	logic               acc;
	logic               issue_last;
	logic [PHASE_W-1:0] step;
	logic [SEQ_W-1:0]   seq_inc;
	op_t                in_op;

	assign in_op      = op_t'(s_tuser);
	assign iss_valid  = busy_q && s2_ready;
	assign issue_last = (cnt_q == LAST_CH);
	assign s_tready   = !busy_q || (issue_last && iss_valid);
	assign acc        = s_tvalid && s_tready;
	assign step       = (phase_step_q == '0) ? PHASE_W'(1) : phase_step_q;
	assign seq_inc    = seq_q + SEQ_W'(1);

	always_comb begin
		iss.op         = item_q.op;
		iss.ch         = cnt_q;
		iss.slot       = item_q.slot;
		iss.phase      = item_q.phase;
		iss.sample     = item_q.samples[cnt_q];
		iss.neg_i      = item_q.neg_i;
		iss.neg_q      = item_q.neg_q;
		iss.hist_fill  = item_q.hist_fill;
		iss.sum_fill   = item_q.sum_fill;
		iss.mean_valid = item_q.mean_valid;
		iss.seq        = item_q.seq;
		iss.last       = issue_last;
	end

	// config writes must come only while idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= PHASE_W'(1);
			i_mask_q     <= '0;
			q_mask_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PHASE_STEP: phase_step_q <= cfg_data[PHASE_W-1:0];
				CFG_I_MASK:     i_mask_q     <= cfg_data;
				CFG_Q_MASK:     q_mask_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// scalar state moves at acceptance; the item keeps a snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			phase_q <= '0;
			ecnt_q  <= '0;
			seq_q   <= '0;
		end else if (acc) begin
			if (in_op == OP_EPOCH) begin
				slot_q  <= slot_q + SLOT_W'(1);
				phase_q <= phase_q + step;
				if (ecnt_q != ECNT_FULL) begin
					ecnt_q <= ecnt_q + ECNT_W'(1);
				end
			end else begin
				seq_q <= seq_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_q.op         <= in_op;
			item_q.samples    <= s_tdata;
			item_q.slot       <= slot_q;
			item_q.phase      <= phase_q;
			item_q.neg_i      <= i_mask_q[phase_q];
			item_q.neg_q      <= q_mask_q[phase_q];
			item_q.hist_fill  <= (ecnt_q == ECNT_FULL);
			item_q.sum_fill   <= (ecnt_q != '0);
			item_q.mean_valid <= (ecnt_q == ECNT_FULL);
			item_q.seq        <= (in_op == OP_REPORT) ? seq_inc : seq_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (acc) begin
				busy_q <= 1'b1;
			end else if (iss_valid && issue_last) begin
				busy_q <= 1'b0;
			end
			if (iss_valid) begin
				cnt_q <= issue_last ? '0 : cnt_q + CH_W'(1);
			end
		end
	end

endmodule

>>> hdl/qcrim_update.sv
// Read-modify-write stage: running sums, delay-line writes and report results.
module qcrim_update (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               iss_valid,
	input  qcrim_pkg::issue_t                  iss,
	input  qcrim_pkg::hist_word_t              hist_rd,
	input  qcrim_pkg::sum_word_t               sum_rd,
	input  logic                               out_ready,
	output logic                               s2_ready,
	output logic                               hist_we,
	output logic [qcrim_pkg::HIST_AW-1:0]      hist_waddr,
	output qcrim_pkg::hist_word_t              hist_wdata,
	output logic                               sum_we,
	output logic [qcrim_pkg::CH_W-1:0]         sum_waddr,
	output qcrim_pkg::sum_word_t               sum_wdata,
	output logic                               res_valid,
	output qcrim_pkg::res_t                    res
);
	import qcrim_pkg::*;

	logic       valid_s2;
	issue_t     iss_s2;
	logic       adv;
	hist_word_t old_h;
	sum_word_t  old_s;
	logic signed [DEMOD_W-1:0] x;
	logic signed [DEMOD_W-1:0] vi;
	logic signed [DEMOD_W-1:0] vq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= iss_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (iss_valid) begin
			iss_s2 <= iss;
		end
	end

	// epochs never wait; reports wait for the output register
	assign adv       = valid_s2 && ((iss_s2.op == OP_EPOCH) || out_ready);
	assign s2_ready  = !valid_s2 || adv;

	// entries not yet written since reset read as zero
	assign old_h = iss_s2.hist_fill ? hist_rd : '0;
	assign old_s = iss_s2.sum_fill ? sum_rd : '0;

	assign x  = {iss_s2.sample[SAMPLE_W-1], iss_s2.sample};
	assign vi = iss_s2.neg_i ? -x : x;
	assign vq = iss_s2.neg_q ? -x : x;

	assign hist_we          = adv && (iss_s2.op == OP_EPOCH);
	assign hist_waddr       = {iss_s2.ch, iss_s2.slot};
	assign hist_wdata.raw   = iss_s2.sample;
	assign hist_wdata.i     = vi;
	assign hist_wdata.q     = vq;

	assign sum_we        = hist_we;
	assign sum_waddr     = iss_s2.ch;
	assign sum_wdata.raw = old_s.raw
		+ {{SLOT_W{iss_s2.sample[SAMPLE_W-1]}}, iss_s2.sample}
		- {{SLOT_W{old_h.raw[SAMPLE_W-1]}}, old_h.raw};
	assign sum_wdata.i   = old_s.i + {{SLOT_W{vi[DEMOD_W-1]}}, vi}
		- {{SLOT_W{old_h.i[DEMOD_W-1]}}, old_h.i};
	assign sum_wdata.q   = old_s.q + {{SLOT_W{vq[DEMOD_W-1]}}, vq}
		- {{SLOT_W{old_h.q[DEMOD_W-1]}}, old_h.q};

	assign res_valid      = valid_s2 && (iss_s2.op == OP_REPORT);
	assign res.ch         = iss_s2.ch;
	assign res.mean_raw   = old_s.raw[RSUM_W-1:SLOT_W];
	assign res.mean_i     = old_s.i[DSUM_W-1:SLOT_W];
	assign res.mean_q     = old_s.q[DSUM_W-1:SLOT_W];
	assign res.phase      = iss_s2.phase;
	assign res.write_pos  = iss_s2.slot;
	assign res.mean_valid = iss_s2.mean_valid;
	assign res.seq        = iss_s2.seq;
	assign res.last       = iss_s2.last;

endmodule

>>> hdl/quad_channel_rolling_iq_mean_unit.sv
// Top level of the quad-channel rolling IQ mean unit.
//
// Slave stream: s_tuser selects the transaction kind (0 = sample epoch,
// 1 = report); s_tdata carries four signed 24-bit samples, channel 0 lowest.
// An epoch updates the eight-deep delay lines and running sums of raw, I and
// Q for each channel and produces nothing. A report bumps the sequence
// number and emits four master transactions, channels 0..3, tlast on the
// last one. Config writes (cfg_we/cfg_index/cfg_data) go in while idle.
//
// Throughput: each item is issued one channel per cycle while the update
// stage is not stalled, as the history and sum memories have a single
// read-modify-write path. A report's first result passes the item, update
// stage and output registers before it shows on m_tvalid.
// Items are taken back to back: the next item is accepted on the cycle the
// previous one issues its last channel.
// Reset clears config and scalar state; the memories are not swept, an entry
// reads as zero until the epoch count shows it has been written.
// When m_tready is low, a result waits in the output register, the update
// stage holds behind it and s_tready drops until the stall clears.
module quad_channel_rolling_iq_mean_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// sample_ch0, sample_ch1, sample_ch2, sample_ch3
	input  logic [qcrim_pkg::S_TDATA_W-1:0]     s_tdata,
	// operation
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// channel, mean_raw, mean_i, mean_q, phase, write_pos, mean_valid,
	// report_seq, zero pad
	output logic [qcrim_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic                                m_tlast,
	input  logic                                cfg_we,
	input  logic [qcrim_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [qcrim_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import qcrim_pkg::*;

	logic       iss_valid;
	issue_t     iss;
	logic       s2_ready;
	hist_word_t hist_rd;
	sum_word_t  sum_rd;
	logic       hist_we;
	logic [HIST_AW-1:0] hist_waddr;
	hist_word_t hist_wdata;
	logic       sum_we;
	logic [CH_W-1:0] sum_waddr;
	sum_word_t  sum_wdata;
	logic       res_valid;
	res_t       res;
	logic       out_ready;
	logic       out_valid_q;
	res_t       out_q;

	qcrim_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s2_ready  (s2_ready),
		.iss_valid (iss_valid),
		.iss       (iss)
	);

	// delay lines, addressed {channel, slot}
	qcrim_ram #(
		.WIDTH ($bits(hist_word_t)),
		.DEPTH (HIST_DEPTH)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.re    (iss_valid),
		.raddr ({iss.ch, iss.slot}),
		.rdata (hist_rd)
	);

	// running sums, one word per channel
	qcrim_ram #(
		.WIDTH ($bits(sum_word_t)),
		.DEPTH (SUM_DEPTH)
	) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.re    (iss_valid),
		.raddr (iss.ch),
		.rdata (sum_rd)
	);

	qcrim_update u_update (
		.clk        (clk),
		.arst_n     (arst_n),
		.iss_valid  (iss_valid),
		.iss        (iss),
		.hist_rd    (hist_rd),
		.sum_rd     (sum_rd),
		.out_ready  (out_ready),
		.s2_ready   (s2_ready),
		.hist_we    (hist_we),
		.hist_waddr (hist_waddr),
		.hist_wdata (hist_wdata),
		.sum_we     (sum_we),
		.sum_waddr  (sum_waddr),
		.sum_wdata  (sum_wdata),
		.res_valid  (res_valid),
		.res        (res)
	);

	// output register between the update stage and the master stream
	assign out_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {
		{(M_TDATA_W - RES_BITS){1'b0}},
		out_q.seq,
		out_q.mean_valid,
		out_q.write_pos,
		out_q.phase,
		out_q.mean_q,
		out_q.mean_i,
		out_q.mean_raw,
		out_q.ch
	};

endmodule
